// ----- hdl/tsfc_pkg.sv -----
// Shared constants, register indexes and handshake structs for the touch
// sample filter / calibration block. No dependencies.
package tsfc_pkg;

  // window defaults
  localparam int SAMPLES_DEF = 32;
  localparam int GOOD_SAMPLES_DEF = 16;

  // pressure and coordinate limits
  localparam logic [15:0] Z_OFFSET = 16'd4095;
  localparam logic [15:0] PRESS_MIN = 16'd500;
  localparam logic [15:0] COORD_LIMIT = 16'd10000;
  localparam logic [7:0] RELEASE_RESET = 8'd10;

  // config register indexes
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_A = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_B = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_C = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_D = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_E = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_F = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DIVISOR = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE = 3'd7;

  // datapath widths: |a*x + b*y + c| < 2^45, so a 46-bit signed sum
  localparam int ACC_W = 46;
  localparam int PROD_W = 45;
  localparam int NUM_W = 46;
  localparam int DEN_W = 32;

  localparam int IN_W = 56;
  localparam int OUT_W = 32;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [NUM_W-1:0] quo;
  } div_rsp_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic add;
  } mac_op_t;

endpackage

// ----- hdl/tsfc_div.sv -----
// Shared restoring divider, unsigned, one quotient bit per cycle.
// Depends on tsfc_pkg for widths and the request/response structs.
module tsfc_div (
  input  logic               clk,
  input  logic               rst,
  input  tsfc_pkg::div_req_t req,
  output tsfc_pkg::div_rsp_t rsp
);
  import tsfc_pkg::*;

  localparam int CNT_W = $clog2(NUM_W);

  logic             busy;
  logic             done;
  logic [DEN_W-1:0] rem;
  logic [NUM_W-1:0] quo;
  logic [DEN_W-1:0] den;
  logic [CNT_W-1:0] cnt;

  logic [DEN_W:0] trial;
  logic [DEN_W:0] diff;

  assign trial = {rem, quo[NUM_W-1]};
  assign diff  = trial - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start && !busy) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start && !busy) begin
      rem <= '0;
      quo <= req.num;
      den <= req.den;
    end else if (busy) begin
      if (!diff[DEN_W]) begin
        rem <= diff[DEN_W-1:0];
        quo <= {quo[NUM_W-2:0], 1'b1};
      end else begin
        rem <= trial[DEN_W-1:0];
        quo <= {quo[NUM_W-2:0], 1'b0};
      end
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.quo  = quo;

endmodule

// ----- hdl/tsfc_mac.sv -----
// Multiply-accumulate for the affine map: registered 32x13 product, then add.
// Depends on tsfc_pkg for widths and the op struct.
module tsfc_mac (
  input  logic                            clk,
  input  tsfc_pkg::mac_op_t               op,
  input  logic signed [31:0]              coef,
  input  logic [11:0]                     opnd,
  output logic signed [tsfc_pkg::ACC_W-1:0] acc
);
  import tsfc_pkg::*;

  logic signed [PROD_W-1:0] prod;
  logic signed [12:0]       opnd_s;

  assign opnd_s = $signed({1'b0, opnd});

  always_ff @(posedge clk) begin
    if (op.mul) begin
      prod <= coef * opnd_s;
    end
    if (op.load) begin
      acc <= ACC_W'(coef);
    end else if (op.add) begin
      acc <= acc + ACC_W'(prod);
    end
  end

endmodule

// ----- hdl/touch_sample_filter_calibrate.sv -----
// Top level: sample windowing, pressed/released tracking and calibration
// sequencer. Depends on tsfc_pkg, tsfc_div and tsfc_mac.
//
// Each input word is one raw resistive-touch conversion. Pressure is
// z = (4095 + z1 - z2) mod 65536 with 4095 read as 0; a sample with z >= 500
// adds its x and y to the window sums. A word that does not close a window is
// taken and gives no output word. The word that closes a window (every
// SAMPLES words) gives exactly one output word. For a released window, or a
// pressed one with a zero divisor, the divider is not used. For a pressed
// window with a nonzero divisor the one shared 46-step restoring divider runs
// four times (average x, average y, calibrated x, calibrated y), with
// multiply-accumulate and sequencing for each calibrated axis. s_tready is
// low from the closing word until its result is loaded into the output
// register; words are still taken while an earlier result waits on m_tready.
// Configuration is written through cfg_we/cfg_index/cfg_data; the user must
// write it only while the block is idle, and the block itself does not enforce
// this. Index 0..5 are the coefficients a..f, 6 the divisor, 7 the release limit.
module touch_sample_filter_calibrate #(
  parameter int SAMPLES      = tsfc_pkg::SAMPLES_DEF,
  parameter int GOOD_SAMPLES = tsfc_pkg::GOOD_SAMPLES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // raw_x[11:0], raw_y[23:12], pressure_z1[36:24], pressure_z2[49:37]
  input  logic [tsfc_pkg::IN_W-1:0]       s_tdata,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // touch_pressed[0], point_new[1], cal_x[15:2], cal_y[29:16]
  output logic [tsfc_pkg::OUT_W-1:0]      m_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  input  logic                            cfg_we,
  input  logic [tsfc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tsfc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import tsfc_pkg::*;

  localparam logic [7:0] SAMPLES_C = 8'(SAMPLES);
  localparam logic [7:0] GOOD_C    = 8'(GOOD_SAMPLES);

  // sequencer states
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CLOSE  = 4'd1;
  localparam logic [3:0] S_AVGX   = 4'd2;
  localparam logic [3:0] S_AVGY   = 4'd3;
  localparam logic [3:0] S_LOADC  = 4'd4;
  localparam logic [3:0] S_MULA   = 4'd5;
  localparam logic [3:0] S_ADDA   = 4'd6;
  localparam logic [3:0] S_MULB   = 4'd7;
  localparam logic [3:0] S_ADDB   = 4'd8;
  localparam logic [3:0] S_QSTART = 4'd9;
  localparam logic [3:0] S_QDIV   = 4'd10;
  localparam logic [3:0] S_OUT    = 4'd11;

  // config registers
  logic signed [31:0] coef_a, coef_b, coef_c, coef_d, coef_e, coef_f;
  logic signed [31:0] divisor;
  logic [7:0]         release_limit;

  // window and tracking state
  logic [3:0]  state;
  logic [7:0]  sample_index;
  logic [7:0]  press_count;
  logic [19:0] sum_x;
  logic [19:0] sum_y;
  logic [7:0]  release_counter;
  logic        pressed_flag;
  logic [15:0] last_x;
  logic [15:0] last_y;
  logic        fresh;

  // calibration working regs
  logic [11:0] avg_x;
  logic [11:0] avg_y;
  logic        axis;    // 0: x, 1: y
  logic        q_neg;

  // output register
  logic        out_pressed;
  logic        out_new;
  logic [13:0] out_x;
  logic [13:0] out_y;

  // input unpack
  logic [11:0] raw_x, raw_y;
  logic [12:0] pressure_z1, pressure_z2;
  assign raw_x       = s_tdata[11:0];
  assign raw_y       = s_tdata[23:12];
  assign pressure_z1 = s_tdata[36:24];
  assign pressure_z2 = s_tdata[49:37];

  logic [15:0] z;
  logic        hit;
  logic [7:0]  idx_inc;
  logic        accept;

  assign z       = Z_OFFSET + {3'b0, pressure_z1} - {3'b0, pressure_z2};
  assign hit     = (z != Z_OFFSET) && (z >= PRESS_MIN);
  assign idx_inc = sample_index + 8'd1;
  assign s_tready = (state == S_IDLE);
  assign accept  = s_tvalid && s_tready;

  // window decision
  logic       win_pressed;
  logic       calib;
  logic [7:0] rc_inc;
  assign win_pressed = (press_count > GOOD_C) && (press_count != 8'd0);
  assign calib       = win_pressed && (divisor != 32'sd0);
  assign rc_inc      = release_counter + 8'd1;

  // shared units
  div_req_t div_req;
  div_rsp_t div_rsp;
  mac_op_t  mac_op;
  logic signed [31:0]    mac_coef;
  logic [11:0]           mac_opnd;
  logic signed [ACC_W-1:0] acc;

  tsfc_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  tsfc_mac u_mac (
    .clk  (clk),
    .op   (mac_op),
    .coef (mac_coef),
    .opnd (mac_opnd),
    .acc  (acc)
  );

  // magnitudes for the signed calibration divide
  logic [NUM_W-1:0] acc_mag;
  logic [DEN_W-1:0] div_mag;
  assign acc_mag = acc[ACC_W-1] ? NUM_W'(-acc) : NUM_W'(acc);
  assign div_mag = divisor[31] ? DEN_W'(-divisor) : DEN_W'(divisor);

  always_comb begin
    div_req.start = 1'b0;
    div_req.num   = acc_mag;
    div_req.den   = div_mag;
    case (state)
      S_CLOSE: begin
        div_req.start = calib;
        div_req.num   = NUM_W'(sum_x);
        div_req.den   = DEN_W'(press_count);
      end
      S_AVGX: begin
        div_req.start = div_rsp.done;
        div_req.num   = NUM_W'(sum_y);
        div_req.den   = DEN_W'(press_count);
      end
      S_QSTART: begin
        div_req.start = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    mac_op.load = (state == S_LOADC);
    mac_op.mul  = (state == S_MULA) || (state == S_MULB);
    mac_op.add  = (state == S_ADDA) || (state == S_ADDB);
    mac_opnd    = (state == S_MULB) ? avg_y : avg_x;
    case (state)
      S_LOADC: mac_coef = axis ? coef_f : coef_c;
      S_MULA:  mac_coef = axis ? coef_d : coef_a;
      S_MULB:  mac_coef = axis ? coef_e : coef_b;
      default: mac_coef = coef_a;
    endcase
  end

  // signed quotient, low 16 bits, out-of-range coordinates read as 0
  logic [15:0] q_low;
  logic [15:0] coord;
  assign q_low = q_neg ? (16'd0 - div_rsp.quo[15:0]) : div_rsp.quo[15:0];
  assign coord = (q_low >= COORD_LIMIT) ? 16'd0 : q_low;

  // config port
  always_ff @(posedge clk) begin
    if (rst) begin
      coef_a        <= '0;
      coef_b        <= '0;
      coef_c        <= '0;
      coef_d        <= '0;
      coef_e        <= '0;
      coef_f        <= '0;
      divisor       <= '0;
      release_limit <= RELEASE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_COEF_A:  coef_a <= cfg_data;
        REG_COEF_B:  coef_b <= cfg_data;
        REG_COEF_C:  coef_c <= cfg_data;
        REG_COEF_D:  coef_d <= cfg_data;
        REG_COEF_E:  coef_e <= cfg_data;
        REG_COEF_F:  coef_f <= cfg_data;
        REG_DIVISOR: divisor <= cfg_data;
        REG_RELEASE: release_limit <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  // sequencer and state
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      sample_index    <= '0;
      press_count     <= '0;
      sum_x           <= '0;
      sum_y           <= '0;
      release_counter <= '0;
      pressed_flag    <= 1'b0;
      last_x          <= '0;
      last_y          <= '0;
      fresh           <= 1'b0;
      axis            <= 1'b0;
      m_tvalid        <= 1'b0;
    end else begin
      // S_OUT reloads the output register itself
      if (m_tvalid && m_tready && (state != S_OUT)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            sample_index <= idx_inc;
            if (hit) begin
              press_count <= press_count + 8'd1;
              sum_x       <= sum_x + 20'(raw_x);
              sum_y       <= sum_y + 20'(raw_y);
            end
            if (idx_inc >= SAMPLES_C) begin
              state <= S_CLOSE;
            end
          end
        end
        S_CLOSE: begin
          fresh <= 1'b0;
          if (win_pressed) begin
            release_counter <= '0;
            state <= calib ? S_AVGX : S_OUT;
          end else begin
            state <= S_OUT;
            if (rc_inc > release_limit) begin
              release_counter <= '0;
              pressed_flag    <= 1'b0;
            end else begin
              release_counter <= rc_inc;
            end
          end
        end
        S_AVGX: begin
          if (div_rsp.done) begin
            state <= S_AVGY;
          end
        end
        S_AVGY: begin
          if (div_rsp.done) begin
            axis  <= 1'b0;
            state <= S_LOADC;
          end
        end
        S_LOADC:  state <= S_MULA;
        S_MULA:   state <= S_ADDA;
        S_ADDA:   state <= S_MULB;
        S_MULB:   state <= S_ADDB;
        S_ADDB:   state <= S_QSTART;
        S_QSTART: state <= S_QDIV;
        S_QDIV: begin
          if (div_rsp.done) begin
            if (!axis) begin
              last_x <= coord;
              axis   <= 1'b1;
              state  <= S_LOADC;
            end else begin
              last_y       <= coord;
              pressed_flag <= 1'b1;
              fresh        <= 1'b1;
              state        <= S_OUT;
            end
          end
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid     <= 1'b1;
            sample_index <= '0;
            press_count  <= '0;
            sum_x        <= '0;
            sum_y        <= '0;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if ((state == S_AVGX) && div_rsp.done) begin
      avg_x <= div_rsp.quo[11:0];
    end
    if ((state == S_AVGY) && div_rsp.done) begin
      avg_y <= div_rsp.quo[11:0];
    end
    if (state == S_QSTART) begin
      q_neg <= acc[ACC_W-1] ^ divisor[31];
    end
    if ((state == S_OUT) && (!m_tvalid || m_tready)) begin
      out_pressed <= pressed_flag;
      out_new     <= fresh;
      out_x       <= last_x[13:0];
      out_y       <= last_y[13:0];
    end
  end

  assign m_tdata = {2'b00, out_y, out_x, out_new, out_pressed};

endmodule

// ----- hdl/tsfc_checker.sv -----
// Port-level checks for touch_sample_filter_calibrate, bound to the top level.
// Depends on tsfc_pkg for port widths and the coordinate limit.
module tsfc_checker (
  input logic                            clk,
  input logic                            rst,
  input logic [tsfc_pkg::OUT_W-1:0]      m_tdata,
  input logic                            m_tvalid,
  input logic                            m_tready
);
  import tsfc_pkg::*;

  // no result word right after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result word valid right after reset");

  // a stalled result word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result word changed");

  // a new point always leaves the pressed flag set
  a_new_pressed: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[1] |-> m_tdata[0])
    else $error("point_new without touch_pressed");

  // coordinates stay in range
  a_coord_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (16'(m_tdata[15:2]) < COORD_LIMIT) &&
                 (16'(m_tdata[29:16]) < COORD_LIMIT))
    else $error("calibrated coordinate out of range");

endmodule

bind touch_sample_filter_calibrate tsfc_checker u_tsfc_checker (.*);

// ----- sim/testbench.sv -----
// Self-checking testbench for touch_sample_filter_calibrate: directed table plus
// randomized sample windows, checked against an in-bench window/calibration model.
// Depends on tsfc_pkg and the touch_sample_filter_calibrate RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import tsfc_pkg::*;

  localparam int WINDOW        = SAMPLES_DEF;       // words per averaging window
  localparam int MIN_PRESSED   = GOOD_SAMPLES_DEF;  // need strictly more than this
  localparam int MAX_GAP       = 11;
  localparam int HOLD_CYCLES   = 3000;              // long m_tready hold-off
  localparam int SETTLE_CYCLES = 250;               // covers a full calibration pass
  localparam int CYCLE_LIMIT   = 200000;
  localparam int RANDOM_PHASES = 7;
  localparam int WINDOWS_PER_PHASE = 3;
  localparam int HOLD_WINDOWS  = 4;                 // enough to back up s_tready
  localparam int HOLD_PHASE    = 4;

  // one input word; first field sits in the low bits
  typedef struct packed {
    logic [12:0] pressure_z2;
    logic [12:0] pressure_z1;
    logic [11:0] raw_y;
    logic [11:0] raw_x;
  } sample_t;

  // one output word, low 30 bits of m_tdata
  typedef struct packed {
    logic [13:0] cal_y;
    logic [13:0] cal_x;
    logic        point_new;
    logic        touch_pressed;
  } report_t;

  typedef struct packed {
    logic [7:0]       release_limit;
    logic [31:0]      divisor;
    logic [5:0][31:0] coef;        // a..f
  } cal_profile_t;

  // calibration register sets; PROF_KEEP leaves the registers alone
  typedef enum {
    PROF_KEEP, PROF_UNITY, PROF_HIGH, PROF_LOW, PROF_NEG,
    PROF_SCREEN, PROF_RANDOM, PROF_NO_DIV
  } profile_e;

  typedef struct {
    profile_e load;     // register set to load before this row
    sample_t  smp;
    int       reps;
    bit       typed;    // use the hand-written report if this row closes a window
    report_t  want;
  } row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic [IN_W-1:0]       s_tdata = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [OUT_W-1:0]      m_tdata;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_COEF_A;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // bench-side copy of the registers and window state
  cal_profile_t cal = '{release_limit: RELEASE_RESET, divisor: '0, coef: '0};
  logic [7:0]   win_count = '0;
  logic [7:0]   hit_count = '0;
  logic [7:0]   idle_windows = '0;
  logic [19:0]  sum_x = '0;
  logic [19:0]  sum_y = '0;
  logic         held = 1'b0;
  logic [15:0]  last_x = '0;
  logic [15:0]  last_y = '0;

  report_t owed_reports[$];   // reports predicted but not yet seen on m_*
  int      failures = 0;
  int      cycles = 0;
  bit      no_idle = 1'b0;    // both sides run back to back
  bit      hold_output = 1'b0;

  touch_sample_filter_calibrate dut (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // pressure with the open-circuit value folded to zero
  function automatic logic [15:0] pressure_of(sample_t s);
    logic [15:0] z;
    z = Z_OFFSET + 16'(s.pressure_z1) - 16'(s.pressure_z2);
    return (z == Z_OFFSET) ? 16'd0 : z;
  endfunction

  // one axis of the affine map, 64-bit math, quotient truncated toward zero
  function automatic logic [15:0] map_axis(logic [31:0] c0, logic [31:0] c1,
                                           logic [31:0] c2, logic [19:0] ax,
                                           logic [19:0] ay);
    longint num;
    longint q;
    logic [15:0] low;
    num = longint'($signed(c0)) * longint'(ax) + longint'($signed(c1)) * longint'(ay)
        + longint'($signed(c2));
    q = num / longint'($signed(cal.divisor));
    low = q[15:0];
    return (low >= COORD_LIMIT) ? 16'd0 : low;
  endfunction

  // advance the window state by one accepted word; closed is set on the
  // word that ends a window, with the report the block must produce
  function automatic void absorb_sample(sample_t s, output bit closed, output report_t r);
    logic [19:0] ax;
    logic [19:0] ay;
    closed = 1'b0;
    r = '0;
    if (pressure_of(s) >= PRESS_MIN) begin
      hit_count = hit_count + 8'd1;
      sum_x = sum_x + 20'(s.raw_x);
      sum_y = sum_y + 20'(s.raw_y);
    end
    win_count = win_count + 8'd1;
    if (win_count < WINDOW) return;
    closed = 1'b1;
    if (hit_count > MIN_PRESSED && hit_count != 0) begin
      ax = sum_x / hit_count;
      ay = sum_y / hit_count;
      idle_windows = '0;
      // zero divisor: pressed, but no new point and flag untouched
      if (cal.divisor != 0) begin
        last_x = map_axis(cal.coef[0], cal.coef[1], cal.coef[2], ax, ay);
        last_y = map_axis(cal.coef[3], cal.coef[4], cal.coef[5], ax, ay);
        held = 1'b1;
        r.point_new = 1'b1;
      end
    end else begin
      idle_windows = idle_windows + 8'd1;
      if (idle_windows > cal.release_limit) begin
        idle_windows = '0;
        held = 1'b0;
      end
    end
    win_count = '0;
    hit_count = '0;
    sum_x = '0;
    sum_y = '0;
    r.touch_pressed = held;
    r.cal_x = last_x[13:0];
    r.cal_y = last_y[13:0];
  endfunction

  function automatic sample_t mk_sample(int x, int y, int z1, int z2);
    sample_t s;
    s.raw_x = 12'(x);
    s.raw_y = 12'(y);
    s.pressure_z1 = 13'(z1);
    s.pressure_z2 = 13'(z2);
    return s;
  endfunction

  function automatic report_t mk_report(bit pressed, bit fresh, int x, int y);
    report_t r;
    r.touch_pressed = pressed;
    r.point_new = fresh;
    r.cal_x = 14'(x);
    r.cal_y = 14'(y);
    return r;
  endfunction

  function automatic cal_profile_t build_profile(profile_e kind);
    cal_profile_t p;
    int unsigned scale;
    p = '0;
    case (kind)
      PROF_UNITY: begin
        p.coef[0] = 32'd1;
        p.coef[4] = 32'd1;
        p.divisor = 32'd1;
        p.release_limit = 8'd0;
      end
      PROF_HIGH: begin
        for (int i = 0; i < 3; i++) p.coef[i] = 32'h7FFF_FFFF;
        for (int i = 3; i < 6; i++) p.coef[i] = 32'h8000_0000;
        p.divisor = 32'h7FFF_FFFF;
        p.release_limit = 8'd254;
      end
      PROF_LOW: begin
        for (int i = 0; i < 6; i++) p.coef[i] = i[0] ? 32'h7FFF_FFFF : 32'h8000_0000;
        p.divisor = 32'h8000_0000;
        p.release_limit = 8'd0;
      end
      PROF_NEG: begin
        for (int i = 0; i < 3; i++) p.coef[i] = '1;
        for (int i = 3; i < 6; i++) p.coef[i] = 32'd1;
        p.divisor = '1;
        p.release_limit = 8'd1;
      end
      PROF_SCREEN: begin
        // plausible panel fit: gain 0..2, small cross term, offset up to 1000
        scale = $urandom_range(256, 65536);
        p.divisor = scale;
        p.coef[0] = $urandom_range(0, 2 * scale);
        p.coef[1] = $urandom_range(0, scale / 4) - scale / 8;
        p.coef[2] = $urandom_range(0, 1000 * scale);
        p.coef[3] = $urandom_range(0, scale / 4) - scale / 8;
        p.coef[4] = $urandom_range(0, 2 * scale);
        p.coef[5] = $urandom_range(0, 1000 * scale);
        if ($urandom_range(0, 1) == 1) begin
          for (int i = 0; i < 6; i++) p.coef[i] = -p.coef[i];
          p.divisor = -p.divisor;
        end
        p.release_limit = 8'($urandom_range(0, 3));
      end
      PROF_RANDOM: begin
        for (int i = 0; i < 6; i++) p.coef[i] = $urandom;
        p.divisor = $urandom;
        p.release_limit = 8'($urandom_range(0, 254));
      end
      PROF_NO_DIV: begin
        for (int i = 0; i < 6; i++) p.coef[i] = $urandom;
        p.release_limit = 8'($urandom_range(0, 3));
      end
      default: ;
    endcase
    return p;
  endfunction

  function automatic void compare_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      failures++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Sender side. Each task starts and ends right after a rising edge, so every
  // drive below is one nonblocking update per signal per time step.
  // ---------------------------------------------------------------------------
  task automatic send_sample(sample_t s, output bit closed, output report_t r);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tdata <= IN_W'(s);
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    absorb_sample(s, closed, r);
  endtask

  // drop valid, let every owed report drain, then give the block time to settle
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (owed_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  task automatic load_profile(profile_e kind);
    cal_profile_t p;
    wait_idle();
    p = build_profile(kind);
    write_reg(REG_COEF_A, p.coef[0]);
    write_reg(REG_COEF_B, p.coef[1]);
    write_reg(REG_COEF_C, p.coef[2]);
    write_reg(REG_COEF_D, p.coef[3]);
    write_reg(REG_COEF_E, p.coef[4]);
    write_reg(REG_COEF_F, p.coef[5]);
    write_reg(REG_DIVISOR, p.divisor);
    write_reg(REG_RELEASE, 32'(p.release_limit));
    cfg_we <= 1'b0;
    cal = p;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver side: random stalls, one long hold-off on request, and a
  // field-by-field check of every accepted output word.
  // ---------------------------------------------------------------------------
  initial begin : drain
    int stall;
    report_t got;
    report_t want;
    wait (rst === 1'b0);
    forever begin
      if (hold_output) begin
        stall = HOLD_CYCLES;
        hold_output = 1'b0;
      end else begin
        stall = no_idle ? 0 : $urandom_range(0, MAX_GAP);
      end
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      got = report_t'(m_tdata[29:0]);
      if (owed_reports.size() == 0) begin
        $display("%0t: unexpected output word, expected none actual %h", $time, m_tdata);
        failures++;
      end else begin
        want = owed_reports.pop_front();
        compare_field("touch_pressed", 16'(want.touch_pressed), 16'(got.touch_pressed));
        compare_field("point_new", 16'(want.point_new), 16'(got.point_new));
        compare_field("cal_x", 16'(want.cal_x), 16'(got.cal_x));
        compare_field("cal_y", 16'(want.cal_y), 16'(got.cal_y));
        compare_field("padding", 16'd0, 16'(m_tdata[OUT_W-1:30]));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus: directed table first, then random windows over several register
  // sets. Windows are always whole, so each phase ends on a closed window.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    row_t     plan[$];
    profile_e phase_plan[RANDOM_PHASES];
    sample_t  s;
    report_t  r;
    bit       closed;
    bit       press;
    int       hits;
    int       left;
    int       zt;

    phase_plan = '{PROF_SCREEN, PROF_RANDOM, PROF_SCREEN, PROF_NO_DIV,
                   PROF_SCREEN, PROF_LOW, PROF_SCREEN};

    // reset register values: zero coefficients and divisor, release limit 10.
    // open-circuit pressure (z1 == z2) reads as zero, so a released window
    plan.push_back('{PROF_KEEP, mk_sample(4095, 4095, 0, 0), 32, 1'b1,
                     mk_report(0, 0, 0, 0)});
    // pressed window with zero divisor: no point, flag stays low
    plan.push_back('{PROF_KEEP, mk_sample(4095, 0, 8191, 0), 17, 1'b0, '0});
    // z = 499, just under the press threshold
    plan.push_back('{PROF_KEEP, mk_sample(0, 4095, 0, 3596), 15, 1'b1,
                     mk_report(0, 0, 0, 0)});
    // identity map; wrapped pressure (z2 > 4095 + z1) plus z = 500 exactly
    plan.push_back('{PROF_UNITY, mk_sample(4095, 0, 0, 8191), 16, 1'b0, '0});
    plan.push_back('{PROF_KEEP, mk_sample(3000, 2000, 0, 3595), 16, 1'b1,
                     mk_report(1, 1, 3547, 1000)});
    // release limit 0: one released window clears the flag, point is kept
    plan.push_back('{PROF_KEEP, mk_sample(0, 0, 0, 3596), 32, 1'b1,
                     mk_report(0, 0, 3547, 1000)});
    // extreme coefficients, just enough pressed samples
    plan.push_back('{PROF_HIGH, mk_sample(4095, 4095, 8191, 0), 17, 1'b0, '0});
    plan.push_back('{PROF_KEEP, mk_sample(0, 0, 4095, 8190), 15, 1'b0, '0});
    plan.push_back('{PROF_LOW, mk_sample(4095, 1, 8191, 8191), 10, 1'b0, '0});
    plan.push_back('{PROF_KEEP, mk_sample(0, 4095, 0, 4096), 22, 1'b0, '0});
    // divisor of -1: negative quotients wrap past the coordinate limit
    plan.push_back('{PROF_NEG, mk_sample(2048, 2047, 1, 0), 32, 1'b0, '0});
    // exactly GOOD_SAMPLES pressed is not enough
    plan.push_back('{PROF_NO_DIV, mk_sample(1234, 567, 600, 100), 16, 1'b0, '0});
    plan.push_back('{PROF_KEEP, mk_sample(0, 0, 0, 4000), 16, 1'b0, '0});

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].load != PROF_KEEP) load_profile(plan[i].load);
      repeat (plan[i].reps) begin
        send_sample(plan[i].smp, closed, r);
        if (closed) owed_reports.push_back(plan[i].typed ? plan[i].want : r);
      end
    end

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      load_profile(phase_plan[ph]);
      no_idle = (ph % 3 == 2) || (ph == HOLD_PHASE);
      // receiver stalls for a long time while words keep coming: the output
      // register fills and the closing word of a later window backs up s_tready
      if (ph == HOLD_PHASE) hold_output = 1'b1;
      repeat ((ph == HOLD_PHASE) ? HOLD_WINDOWS : WINDOWS_PER_PHASE) begin
        case ($urandom_range(0, 5))
          0:       hits = 0;
          1:       hits = MIN_PRESSED;
          2:       hits = MIN_PRESSED + 1;
          3:       hits = WINDOW;
          default: hits = $urandom_range(0, WINDOW);
        endcase
        left = hits;
        for (int k = 0; k < WINDOW; k++) begin
          // spread exactly 'hits' pressed samples over the window
          press = $urandom_range(0, WINDOW - 1 - k) < left;
          s.raw_x = 12'($urandom_range(0, 4095));
          s.raw_y = 12'($urandom_range(0, 4095));
          if (press) begin
            left--;
            if ($urandom_range(0, 7) == 0) begin
              s.pressure_z1 = 13'($urandom_range(0, 4596));   // z lands on 500
              s.pressure_z2 = s.pressure_z1 + 13'd3595;
            end else begin
              do begin
                s.pressure_z1 = 13'($urandom);
                s.pressure_z2 = 13'($urandom);
              end while (pressure_of(s) < PRESS_MIN);
            end
          end else if ($urandom_range(0, 7) == 0) begin
            s.pressure_z1 = 13'($urandom);                    // open circuit
            s.pressure_z2 = s.pressure_z1;
          end else begin
            zt = $urandom_range(0, PRESS_MIN - 1);
            s.pressure_z1 = 13'($urandom_range(0, 4096 + zt));
            s.pressure_z2 = 13'(int'(s.pressure_z1) + int'(Z_OFFSET) - zt);
          end
          send_sample(s, closed, r);
          if (closed) owed_reports.push_back(r);
        end
      end
    end

    wait_idle();
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- touch_sample_filter_calibrate.f -----
hdl/tsfc_pkg.sv
hdl/tsfc_div.sv
hdl/tsfc_mac.sv
hdl/touch_sample_filter_calibrate.sv
hdl/tsfc_checker.sv
sim/testbench.sv
